>>> hw/rtl/dsc_pkg.sv
// Shared types and constants for the datagram sequence checker with byte ring.
package dsc_pkg;

  localparam int unsigned RING_BYTES   = 65536;
  localparam int unsigned MAX_DATAGRAM = 2048;
  localparam int unsigned SEQ_HEADER   = 4;
  localparam logic [31:0] HALF_RANGE   = 32'h8000_0000;
  localparam int unsigned RES_DEPTH    = 4;

  localparam int unsigned ADDR_W  = $clog2(RING_BYTES);
  localparam int unsigned FILL_W  = $clog2(RING_BYTES + 1);
  localparam int unsigned POS_W   = $clog2(MAX_DATAGRAM);
  localparam int unsigned LEN_W   = 12;
  localparam int unsigned RCNT_W  = $clog2(RES_DEPTH + 1);
  localparam int unsigned RPTR_W  = $clog2(RES_DEPTH);

  localparam logic MODE_BYTE  = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [7:0]       rx_byte;
    logic [LEN_W-1:0] frame_len;
  } dsc_in_t;

  typedef struct packed {
    logic [7:0]        drain_byte;
    logic              drain_valid;
    logic [FILL_W-1:0] fill_level;
    logic [63:0]       gap_events;
    logic [63:0]       lost_frames;
    logic [63:0]       dropped_bytes;
    logic [63:0]       packet_count;
    logic [63:0]       payload_count;
  } dsc_out_t;

  // What the front end decided for one item; the back end applies it.
  typedef struct packed {
    logic              drain_valid;
    logic [FILL_W-1:0] fill_level;
    logic              gap_inc;
    logic [31:0]       lost_inc;
    logic              pkt_inc;
    logic              pay_inc;
    logic              drop_inc;
  } dsc_desc_t;

endpackage

>>> hw/rtl/dsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/dsc_front.sv
// Front end: datagram position tracking, sequence check, ring admission and pointers.
module dsc_front import dsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  dsc_in_t           item_i,
  output dsc_desc_t         desc_o,
  output logic              ram_we_o,
  output logic [ADDR_W-1:0] ram_waddr_o,
  output logic [7:0]        ram_wdata_o,
  output logic              ram_re_o,
  output logic [ADDR_W-1:0] ram_raddr_o
);

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [31:0]       seq_q, seq_d;
  logic [31:0]       prev_q, prev_d;
  logic              have_prev_q, have_prev_d;
  logic              accept_q, accept_d;
  logic [ADDR_W-1:0] wptr_q, wptr_d;
  logic [ADDR_W-1:0] rptr_q, rptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;

  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  pos_ext;
  logic [LEN_W-1:0]  len_m4;
  logic [31:0]       need;
  logic [31:0]       seq_next;
  logic [31:0]       diff;
  logic              is_byte;
  logic              in_header;
  logic              in_payload;
  logic              acc_now;
  logic              store;
  logic              drain;

  always_comb begin
    if (item_i.frame_len == '0) begin
      len = LEN_W'(1);
    end else if (32'(item_i.frame_len) > 32'(MAX_DATAGRAM)) begin
      len = LEN_W'(MAX_DATAGRAM);
    end else begin
      len = item_i.frame_len;
    end
  end

  assign pos_ext    = LEN_W'(pos_q);
  assign len_m4     = len - LEN_W'(SEQ_HEADER);
  assign is_byte    = take_i && (item_i.mode == MODE_BYTE);
  assign in_header  = is_byte && (len >= LEN_W'(SEQ_HEADER)) && (pos_ext < LEN_W'(SEQ_HEADER));
  assign in_payload = is_byte && (len >= LEN_W'(SEQ_HEADER)) && (pos_ext >= LEN_W'(SEQ_HEADER));
  assign seq_next   = {seq_q[23:0], item_i.rx_byte};
  assign diff       = seq_next - prev_q;
  assign need       = 32'(fill_q) + 32'(len_m4);

  // The admission decision is taken at the first payload byte and held for the rest.
  assign acc_now = (pos_ext == LEN_W'(SEQ_HEADER)) ? (need <= 32'(RING_BYTES)) : accept_q;
  assign store   = in_payload && acc_now && (32'(fill_q) < 32'(RING_BYTES));
  assign drain   = take_i && (item_i.mode == MODE_DRAIN) && (fill_q != '0);

  always_comb begin
    pos_d       = pos_q;
    seq_d       = seq_q;
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    accept_d    = accept_q;
    wptr_d      = wptr_q;
    rptr_d      = rptr_q;
    fill_d      = fill_q;

    desc_o          = '0;
    desc_o.pay_inc  = in_payload;
    desc_o.drop_inc = in_payload && !store;

    if (in_header) begin
      seq_d = seq_next;
      if (pos_ext == LEN_W'(SEQ_HEADER - 1)) begin
        if (have_prev_q && (diff != 32'd1) && (diff != 32'd0) && (diff < HALF_RANGE)) begin
          desc_o.gap_inc  = 1'b1;
          desc_o.lost_inc = diff - 32'd1;
        end
        prev_d         = seq_next;
        have_prev_d    = 1'b1;
        desc_o.pkt_inc = 1'b1;
      end
    end

    if (in_payload && (pos_ext == LEN_W'(SEQ_HEADER))) begin
      accept_d = acc_now;
    end

    if (is_byte) begin
      if ((pos_ext + LEN_W'(1)) >= len) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + POS_W'(1);
      end
    end

    if (store) begin
      wptr_d = (wptr_q == ADDR_W'(RING_BYTES - 1)) ? '0 : wptr_q + ADDR_W'(1);
      fill_d = fill_q + FILL_W'(1);
    end else if (drain) begin
      rptr_d = (rptr_q == ADDR_W'(RING_BYTES - 1)) ? '0 : rptr_q + ADDR_W'(1);
      fill_d = fill_q - FILL_W'(1);
    end

    desc_o.drain_valid = drain;
    desc_o.fill_level  = fill_d;
  end

  assign ram_we_o    = store;
  assign ram_waddr_o = wptr_q;
  assign ram_wdata_o = item_i.rx_byte;
  assign ram_re_o    = drain;
  assign ram_raddr_o = rptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      seq_q       <= '0;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      accept_q    <= 1'b0;
      wptr_q      <= '0;
      rptr_q      <= '0;
      fill_q      <= '0;
    end else begin
      pos_q       <= pos_d;
      seq_q       <= seq_d;
      prev_q      <= prev_d;
      have_prev_q <= have_prev_d;
      accept_q    <= accept_d;
      wptr_q      <= wptr_d;
      rptr_q      <= rptr_d;
      fill_q      <= fill_d;
    end
  end

endmodule

>>> hw/rtl/dsc_back.sv
// Back end: holds the statistics counters and assembles each result with the ring read data.
module dsc_back import dsc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      desc_valid_i,
  input  dsc_desc_t desc_i,
  input  logic [7:0] ram_rdata_i,
  output logic      busy_o,
  output logic      res_valid_o,
  output dsc_out_t  res_o
);

  logic        stage_v_q;
  dsc_desc_t   desc_q;
  logic [63:0] gap_q, gap_d;
  logic [63:0] lost_q, lost_d;
  logic [63:0] drop_q, drop_d;
  logic [63:0] pkt_q, pkt_d;
  logic [63:0] pay_q, pay_d;

  assign gap_d  = gap_q  + 64'(desc_q.gap_inc);
  assign lost_d = lost_q + 64'(desc_q.lost_inc);
  assign drop_d = drop_q + 64'(desc_q.drop_inc);
  assign pkt_d  = pkt_q  + 64'(desc_q.pkt_inc);
  assign pay_d  = pay_q  + 64'(desc_q.pay_inc);

  // The ring read issued with the item returns in the cycle the descriptor sits here.
  always_comb begin
    res_o.drain_byte    = desc_q.drain_valid ? ram_rdata_i : 8'd0;
    res_o.drain_valid   = desc_q.drain_valid;
    res_o.fill_level    = desc_q.fill_level;
    res_o.gap_events    = gap_d;
    res_o.lost_frames   = lost_d;
    res_o.dropped_bytes = drop_d;
    res_o.packet_count  = pkt_d;
    res_o.payload_count = pay_d;
  end

  assign res_valid_o = stage_v_q;
  assign busy_o      = stage_v_q;

  always_ff @(posedge clk_i) begin
    if (desc_valid_i) begin
      desc_q <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
      gap_q     <= '0;
      lost_q    <= '0;
      drop_q    <= '0;
      pkt_q     <= '0;
      pay_q     <= '0;
    end else begin
      stage_v_q <= desc_valid_i;
      if (stage_v_q) begin
        gap_q  <= gap_d;
        lost_q <= lost_d;
        drop_q <= drop_d;
        pkt_q  <= pkt_d;
        pay_q  <= pay_d;
      end
    end
  end

endmodule

>>> hw/rtl/dsc_res_fifo.sv
// Small result queue between the back end and the output port.
module dsc_res_fifo import dsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dsc_out_t          data_i,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [RCNT_W-1:0] count_o,
  output dsc_out_t          data_o
);

  dsc_out_t          entry_q [RES_DEPTH];
  logic [RPTR_W-1:0] wr_q, rd_q;
  logic [RCNT_W-1:0] cnt_q;
  logic              do_push;
  logic              do_pop;

  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = entry_q[rd_q];
  assign do_pop  = pop_i && !empty_o;
  assign do_push = push_i && (cnt_q != RCNT_W'(RES_DEPTH));

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == RPTR_W'(RES_DEPTH - 1)) ? '0 : wr_q + RPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == RPTR_W'(RES_DEPTH - 1)) ? '0 : rd_q + RPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + RCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - RCNT_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/datagram_seq_check_byte_fifo.sv
// An accepted item's result is registered in the back-end stage and then in the result queue.
// Throughput: one item per cycle while full is low; the ring RAM has one write and one read
// port, so a stored payload byte and a drain never contend, as each item is one or the other.
// full rises when the back-end stage and the four-entry result queue hold four items.
// Reset clears the pointers, fill level, sequence state and counters; the ring RAM
// itself is not cleared, and only bytes written since reset are ever read.
module datagram_seq_check_byte_fifo import dsc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  dsc_in_t  in_item_i,
  output logic     empty,
  input  logic     pop,
  output dsc_out_t out_item_o
);

  logic              take;
  dsc_desc_t         desc;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic              back_busy;
  logic              res_valid;
  dsc_out_t          res;
  logic [RCNT_W-1:0] res_count;
  logic [RCNT_W:0]   in_flight;

  assign in_flight = (RCNT_W + 1)'(res_count) + (RCNT_W + 1)'(back_busy);
  assign full      = (in_flight >= (RCNT_W + 1)'(RES_DEPTH));
  assign take      = push && !full;

  dsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .item_i      (in_item_i),
    .desc_o      (desc),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr)
  );

  dsc_ram #(
    .WIDTH (8),
    .DEPTH (RING_BYTES)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dsc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (take),
    .desc_i       (desc),
    .ram_rdata_i  (ram_rdata),
    .busy_o       (back_busy),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  dsc_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .pop_i   (pop),
    .empty_o (empty),
    .count_o (res_count),
    .data_o  (out_item_o)
  );

endmodule

>>> hw/rtl/dsc_checker.sv
// Port-level checks for the datagram sequence checker, bound to the top level.
module dsc_checker import dsc_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     push,
  input logic     full,
  input logic     empty,
  input logic     pop,
  input dsc_out_t out_item_o
);

  // An item taken while nothing is queued must reach the result queue via the back-end stage.
  a_result_arrives: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && empty) |=> ##1 !empty)
    else $error("accepted item produced no result");

  // A result that is not taken stays on the ports unchanged.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting result changed or vanished");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (32'(out_item_o.fill_level) <= 32'(RING_BYTES)))
    else $error("fill level beyond ring size");

  // A gap needs a previous datagram, so gaps always trail datagrams.
  a_gap_vs_packets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((out_item_o.gap_events == 64'd0) ||
                (out_item_o.gap_events < out_item_o.packet_count)))
    else $error("more gap events than datagrams allow");

endmodule

bind datagram_seq_check_byte_fifo dsc_checker u_dsc_checker (.*);

>>> tb/sv/dsc_tb_pkg.sv
// Scoreboard for the datagram sequence checker: its own model of the ring and counters.
`timescale 1ns / 100ps

package dsc_tb_pkg;
  import dsc_pkg::*;

  class dsc_scoreboard;
    dsc_out_t          status_q[$];
    int unsigned       mismatches;
    int unsigned       item_count;
    int unsigned       result_count;
    int unsigned       frame_pos;
    logic [7:0]        ring_copy [RING_BYTES];
    logic [FILL_W-1:0] wr_ptr;
    logic [FILL_W-1:0] rd_ptr;
    logic [31:0]       seq_acc;
    logic [31:0]       last_seq;
    bit                seen_seq;
    bit                storing;
    logic [63:0]       gaps;
    logic [63:0]       lost;
    logic [63:0]       drops;
    logic [63:0]       packets;
    logic [63:0]       payloads;

    function new();
      mismatches   = 0;
      item_count   = 0;
      result_count = 0;
      frame_pos    = 0;
      wr_ptr       = '0;
      rd_ptr       = '0;
      seq_acc      = '0;
      last_seq     = '0;
      seen_seq     = 1'b0;
      storing      = 1'b0;
      gaps         = '0;
      lost         = '0;
      drops        = '0;
      packets      = '0;
      payloads     = '0;
    endfunction

    // The pointers run modulo twice the ring size, so their difference is the fill level.
    function logic [FILL_W-1:0] ring_fill();
      return wr_ptr - rd_ptr;
    endfunction

    function int unsigned pending();
      return status_q.size();
    endfunction

    // Applies one accepted item and queues the status it must produce.
    function void add_item(dsc_in_t it);
      dsc_out_t    st;
      int unsigned len;
      logic [31:0] delta;
      st = '0;
      item_count++;
      if (it.mode == MODE_DRAIN) begin
        if (ring_fill() != 0) begin
          st.drain_byte  = ring_copy[rd_ptr[ADDR_W-1:0]];
          st.drain_valid = 1'b1;
          rd_ptr++;
        end
      end else begin
        len = 32'(it.frame_len);
        if (len == 0) begin
          len = 1;
        end else if (len > MAX_DATAGRAM) begin
          len = MAX_DATAGRAM;
        end
        if (len >= SEQ_HEADER) begin
          if (frame_pos < SEQ_HEADER) begin
            seq_acc = {seq_acc[23:0], it.rx_byte};
            if (frame_pos == SEQ_HEADER - 1) begin
              delta = seq_acc - last_seq;
              if (seen_seq && delta != 32'd1 && delta != 32'd0 && delta < HALF_RANGE) begin
                gaps++;
                lost += {32'd0, delta - 32'd1};
              end
              last_seq = seq_acc;
              seen_seq = 1'b1;
              packets++;
            end
          end else begin
            // Room is judged once, at the first payload byte, for the whole payload.
            if (frame_pos == SEQ_HEADER) begin
              storing = (RING_BYTES - ring_fill()) >= (len - SEQ_HEADER);
            end
            payloads++;
            if (storing && ring_fill() < RING_BYTES) begin
              ring_copy[wr_ptr[ADDR_W-1:0]] = it.rx_byte;
              wr_ptr++;
            end else begin
              drops++;
            end
          end
        end
        frame_pos = (frame_pos + 1 >= len) ? 0 : frame_pos + 1;
      end
      st.fill_level    = ring_fill();
      st.gap_events    = gaps;
      st.lost_frames   = lost;
      st.dropped_bytes = drops;
      st.packet_count  = packets;
      st.payload_count = payloads;
      status_q.push_back(st);
    endfunction

    task note_mismatch(string msg);
      if (mismatches < 40) begin
        $display("mismatch at result %0d: %s", result_count, msg);
      end
      mismatches++;
    endtask

    task cmp_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
        note_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      end
    endtask

    task check_result(dsc_out_t got);
      dsc_out_t want;
      result_count++;
      if (status_q.size() == 0) begin
        note_mismatch("result arrived with no item outstanding");
        return;
      end
      want = status_q.pop_front();
      cmp_field("drain_byte", 64'(got.drain_byte), 64'(want.drain_byte));
      cmp_field("drain_valid", 64'(got.drain_valid), 64'(want.drain_valid));
      cmp_field("fill_level", 64'(got.fill_level), 64'(want.fill_level));
      cmp_field("gap_events", got.gap_events, want.gap_events);
      cmp_field("lost_frames", got.lost_frames, want.lost_frames);
      cmp_field("dropped_bytes", got.dropped_bytes, want.dropped_bytes);
      cmp_field("packet_count", got.packet_count, want.packet_count);
      cmp_field("payload_count", got.payload_count, want.payload_count);
    endtask
  endclass

endpackage

>>> tb/sv/tb_datagram_seq_check_byte_fifo.sv
// Testbench top for the datagram sequence checker with its byte ring.
`timescale 1ns / 100ps

module tb_datagram_seq_check_byte_fifo;
  import dsc_pkg::*;
  import dsc_tb_pkg::*;

  localparam int unsigned STALL_LIMIT = 500;
  localparam int unsigned RANDOM_HALF = 450;

  logic     clk_i   = 1'b0;
  logic     rst_ni  = 1'b0;
  logic     push    = 1'b0;
  logic     pop     = 1'b0;
  dsc_in_t  in_item = '0;
  logic     full;
  logic     empty;
  dsc_out_t out_item;

  int unsigned   stall_cycles = 0;
  logic [31:0]   next_seq     = '0;
  dsc_scoreboard sb;

  datagram_seq_check_byte_fifo u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  always #10 clk_i = ~clk_i;

  // Ends the run if neither side moves an item for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic int unsigned frame_bytes(logic [LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > MAX_DATAGRAM) return MAX_DATAGRAM;
    return 32'(len);
  endfunction

  task automatic send_item(input logic mode, input logic [7:0] data,
                           input logic [LEN_W-1:0] len);
    dsc_in_t     it;
    int unsigned gap;
    it.mode      = mode;
    it.rx_byte   = data;
    it.frame_len = len;
    gap = $urandom_range(9);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full);
    sb.add_item(it);
  endtask

  task automatic send_drain();
    send_item(MODE_DRAIN, 8'($urandom_range(255)), LEN_W'($urandom_range(4095)));
  endtask

  // Sends nb bytes: the sequence number big-endian, then random payload. From byte
  // switch_at on (when non-zero) the length field carries len2 instead of len.
  task automatic send_datagram(input logic [31:0] seq, input logic [LEN_W-1:0] len,
                               input int unsigned nb, input int unsigned switch_at,
                               input logic [LEN_W-1:0] len2, input int unsigned drain_pct);
    logic [7:0]       data;
    logic [LEN_W-1:0] cur_len;
    for (int i = 0; i < nb; i++) begin
      while ($urandom_range(99) < drain_pct) send_drain();
      data    = (i < 4) ? seq[31 - 8*i -: 8] : 8'($urandom_range(255));
      cur_len = (switch_at != 0 && i >= switch_at) ? len2 : len;
      send_item(MODE_BYTE, data, cur_len);
    end
  endtask

  // A one-byte datagram always closes whatever datagram the block thinks is open.
  task automatic realign();
    if (sb.frame_pos != 0) send_item(MODE_BYTE, 8'($urandom_range(255)), LEN_W'(1));
  endtask

  task automatic random_datagram(input int unsigned drain_pct);
    int unsigned      pick;
    int unsigned      nb;
    int unsigned      switch_at;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] len2;
    logic [31:0]      seq;
    pick = $urandom_range(99);
    if (pick < 55) begin
      seq = next_seq + 32'd1;
    end else if (pick < 65) begin
      seq = next_seq;
    end else if (pick < 75) begin
      seq = next_seq + 32'($urandom_range(2, 40));
    end else if (pick < 82) begin
      seq = next_seq - 32'($urandom_range(1, 40));
    end else if (pick < 87) begin
      seq = next_seq + 32'h7FFF_FFFF;
    end else if (pick < 92) begin
      seq = next_seq + HALF_RANGE;
    end else begin
      seq = $urandom;
    end
    next_seq = seq;
    pick = $urandom_range(99);
    if (pick < 80) begin
      len = LEN_W'($urandom_range(4, 28));
    end else if (pick < 92) begin
      len = LEN_W'($urandom_range(1, 3));
    end else if (pick < 96) begin
      len = '0;
    end else begin
      len = LEN_W'($urandom_range(29, 300));
    end
    nb        = frame_bytes(len);
    switch_at = 0;
    len2      = len;
    pick = $urandom_range(99);
    if (pick < 6) begin
      switch_at = $urandom_range(1, nb);
      len2      = LEN_W'($urandom_range(0, 40));
    end else if (pick < 10) begin
      nb = $urandom_range(1, nb);
    end
    realign();
    send_datagram(seq, len, nb, switch_at, len2, drain_pct);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic directed_items();
    send_drain();
    // A zero length counts as a one-byte datagram and is ignored.
    send_item(MODE_BYTE, 8'h00, '0);
    send_datagram(32'hFFFF_FFFF, LEN_W'(3), 3, 0, '0, 0);
    send_datagram(32'hFFFF_FFFF, LEN_W'(6), 6, 0, '0, 0);
    // Wraps forward by one, then repeats, then takes the largest jump still counted.
    send_datagram(32'h0000_0000, LEN_W'(4), 4, 0, '0, 0);
    send_datagram(32'h0000_0000, LEN_W'(4), 4, 0, '0, 0);
    send_datagram(32'h7FFF_FFFF, LEN_W'(4), 4, 0, '0, 0);
    send_drain();
    send_drain();
    next_seq = 32'h7FFF_FFFF;
  endtask

  task automatic collect_status();
    int unsigned gap;
    forever begin
      gap = $urandom_range(9);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      sb.check_result(out_item);
    end
  endtask

  initial begin
    int unsigned target;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fork
      collect_status();
    join_none

    directed_items();
    settle();

    target = sb.item_count + RANDOM_HALF;
    while (sb.item_count < target) random_datagram(30);
    settle();

    target = sb.item_count + RANDOM_HALF;
    while (sb.item_count < target) random_datagram(50);
    settle();

    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
